// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/fqd_pkg.sv
// ----------------------------------------------------------------------------
// fqd_pkg
// types and codes shared by the queue top level and its storage cells
// ----------------------------------------------------------------------------
package fqd_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 64;

    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_REMOVE  = 2'd1;
    localparam logic [1:0] ACT_DUMP    = 2'd2;

    localparam logic [2:0] STAT_DONE      = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [2:0] STAT_EMPTY     = 3'd3;
    localparam logic [2:0] STAT_ENTRY     = 3'd4;

    // commands broadcast to every cell of the chain
    typedef struct packed {
        logic enq;
        logic rem;
        logic rot;
    } ctrl_t;

endpackage

// File: sv/fqd_cell.sv
// ----------------------------------------------------------------------------
// fqd_cell
// one queue slot: holds an entry, appends, closes gaps and rotates for dump
// ----------------------------------------------------------------------------
module fqd_cell
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  fqd_pkg::ctrl_t                     ctrl,
    input  logic signed [fqd_pkg::DATA_W-1:0]  value,
    input  logic                               prev_valid,
    input  logic                               next_valid,
    input  logic signed [fqd_pkg::DATA_W-1:0]  next_data,
    input  logic signed [fqd_pkg::DATA_W-1:0]  head_data,
    input  logic                               hit_in,
    output logic                               hit_out,
    output logic                               valid,
    output logic signed [fqd_pkg::DATA_W-1:0]  data
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [fqd_pkg::DATA_W-1:0] data_reg;
    logic signed [fqd_pkg::DATA_W-1:0] data_next;
    logic                              match;
    logic                              shift;

    assign match   = valid_reg && (data_reg == value);
    assign hit_out = hit_in || match;
    // every slot from the first match onward pulls from its neighbor
    assign shift   = ctrl.rem && hit_out;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.enq && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            data_next  = value;
        end
        else if (shift)
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
        else if (ctrl.rot && valid_reg)
        begin
            // last occupied slot wraps around to the head
            data_next = next_valid ? next_data : head_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// File: sv/fifo_queue_delete_by_value.sv
// ----------------------------------------------------------------------------
// fifo_queue_delete_by_value
// ordered queue of signed words with append, delete-by-value and dump
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Enqueue and remove
// finish in the cycle they are taken: every slot compares against the value
// at once and the slots from the first match onward pull from their neighbor.
// Their single result appears on the next cycle and a new command may be
// given in that same cycle. Dump of a non-empty queue rotates the slot chain
// once per cycle and emits the head each time, so it holds busy until the last
// stored entry has been taken from the head; an empty dump gives one result.
// Results are shown for exactly one cycle with strobe high and cannot be held
// off by the receiver. Action code 3 is ignored.
module fifo_queue_delete_by_value
#(
    parameter int DEPTH = fqd_pkg::DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         action,
    input  logic signed [fqd_pkg::DATA_W-1:0]  value,
    output logic                               strobe,
    output logic [2:0]                         status,
    output logic signed [fqd_pkg::DATA_W-1:0]  entry,
    output logic                               last
);

`include "assert_macros.svh"

    localparam int OCC_W = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t                            state_reg;
    logic [OCC_W-1:0]                  occ_reg;
    logic [OCC_W-1:0]                  cnt_reg;
    logic                              strobe_reg;
    logic [2:0]                        status_reg;
    logic signed [fqd_pkg::DATA_W-1:0] entry_reg;
    logic                              last_reg;

    logic                              accept;
    logic                              full;
    logic                              found;
    logic                              dump_last;
    fqd_pkg::ctrl_t                    ctrl;

    logic [DEPTH-1:0]                  valid_vec;
    logic signed [fqd_pkg::DATA_W-1:0] data_arr [DEPTH];
    logic [DEPTH:0]                    hit;

    assign busy      = (state_reg == S_DUMP);
    assign accept    = start && !busy;
    assign full      = (occ_reg == OCC_W'(DEPTH));
    assign found     = hit[DEPTH];
    assign dump_last = (cnt_reg == (occ_reg - OCC_W'(1)));

    assign ctrl.enq = accept && (action == fqd_pkg::ACT_ENQUEUE) && !full;
    assign ctrl.rem = accept && (action == fqd_pkg::ACT_REMOVE);
    assign ctrl.rot = (state_reg == S_DUMP);

    assign hit[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                              prev_v;
            logic                              next_v;
            logic signed [fqd_pkg::DATA_W-1:0] next_d;

            if (gi == 0)
            begin : g_first
                assign prev_v = 1'b1;
            end
            else
            begin : g_mid
                assign prev_v = valid_vec[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign next_v = 1'b0;
                assign next_d = '0;
            end
            else
            begin : g_inner
                assign next_v = valid_vec[gi+1];
                assign next_d = data_arr[gi+1];
            end

            fqd_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .value      (value),
                .prev_valid (prev_v),
                .next_valid (next_v),
                .next_data  (next_d),
                .head_data  (data_arr[0]),
                .hit_in     (hit[gi]),
                .hit_out    (hit[gi+1]),
                .valid      (valid_vec[gi]),
                .data       (data_arr[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
            status_reg <= fqd_pkg::STAT_DONE;
            entry_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    strobe_reg <= 1'b0;
                    entry_reg  <= '0;
                    last_reg   <= 1'b1;
                    if (accept)
                    begin
                        case (action)
                            fqd_pkg::ACT_ENQUEUE:
                            begin
                                strobe_reg <= 1'b1;
                                if (full)
                                begin
                                    status_reg <= fqd_pkg::STAT_FULL;
                                end
                                else
                                begin
                                    status_reg <= fqd_pkg::STAT_DONE;
                                    occ_reg    <= occ_reg + OCC_W'(1);
                                end
                            end
                            fqd_pkg::ACT_REMOVE:
                            begin
                                strobe_reg <= 1'b1;
                                if (found)
                                begin
                                    status_reg <= fqd_pkg::STAT_DONE;
                                    occ_reg    <= occ_reg - OCC_W'(1);
                                end
                                else
                                begin
                                    status_reg <= fqd_pkg::STAT_NOT_FOUND;
                                end
                            end
                            fqd_pkg::ACT_DUMP:
                            begin
                                if (occ_reg == '0)
                                begin
                                    strobe_reg <= 1'b1;
                                    status_reg <= fqd_pkg::STAT_EMPTY;
                                end
                                else
                                begin
                                    state_reg <= S_DUMP;
                                    cnt_reg   <= '0;
                                end
                            end
                            default:
                            begin
                                strobe_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                S_DUMP:
                begin
                    // head slot is emitted while the chain rotates under it
                    strobe_reg <= 1'b1;
                    status_reg <= fqd_pkg::STAT_ENTRY;
                    entry_reg  <= data_arr[0];
                    last_reg   <= dump_last;
                    cnt_reg    <= cnt_reg + OCC_W'(1);
                    if (dump_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign strobe = strobe_reg;
    assign status = status_reg;
    assign entry  = entry_reg;
    assign last   = last_reg;

    // occupied slots always form a contiguous run from the head
    `ASSERT_NEVER(a_valid_contig, ((valid_vec >> 1) & ~valid_vec) != '0, "slot gap in chain")
    `ASSERT_ALWAYS(a_occ_match, $countones(valid_vec) == occ_reg, "count differs from slots")
    `ASSERT_NEVER(a_occ_range, occ_reg > OCC_W'(DEPTH), "occupancy above depth")
    `ASSERT_ALWAYS(a_dump_emits, busy |=> strobe && (status == fqd_pkg::STAT_ENTRY),
                   "dump cycle without entry transfer")

endmodule
